### hw/rtl/wred_pkg.sv
// shared types, constants and register codes for the windowed rise event detector
package wred_pkg;

   localparam int CHANNELS_DEF   = 5;
   localparam int WINDOW_MAX_DEF = 64;

   localparam int SAMPLE_W    = 16;
   localparam int PORT_CHANS  = 5;
   localparam int FINGER_W    = 3;
   localparam int WLEN_W      = 7;
   localparam int THRESH_W    = 17;
   localparam int GAP_W       = 16;
   localparam int CSR_DATA_W  = 17;
   localparam int CSR_INDEX_W = 2;
   localparam int HOLD_W      = 18;
   localparam int RISE_W      = 18;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [HOLD_W-1:0]   hold_type;
   typedef logic signed [RISE_W-1:0]   rise_type;

   localparam hold_type HOLD_NEVER = -18'sd1;
   localparam hold_type HOLD_MAX   = 18'sd131071;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_LENGTH  = 2'd0,
      CSR_RISE_THRESHOLD = 2'd1,
      CSR_MIN_GAP        = 2'd2,
      CSR_EVENT_ENABLE   = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_SAMPLE  = 1'b0,
      OP_CONSUME = 1'b1
   } opcode_type;

   localparam logic [WLEN_W-1:0]     WLEN_RESET   = 7'd16;
   localparam logic [THRESH_W-1:0]   THRESH_RESET = 17'd1000;
   localparam logic [GAP_W-1:0]      GAP_RESET    = 16'd0;
   localparam logic                  EN_RESET     = 1'b1;

endpackage

### hw/rtl/wred_window.sv
// per-position sample window memory with a clearing sweep after reset
module wred_window import wred_pkg::*; #(
   parameter int ROW_W = CHANNELS_DEF * SAMPLE_W,
   parameter int DEPTH = WINDOW_MAX_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [ROW_W-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [ROW_W-1:0]         rd_data,
   output logic                     busy
);

   localparam int ADDR_W = $clog2(DEPTH);

   logic [ROW_W-1:0]  mem [DEPTH];
   logic [ROW_W-1:0]  rd_data_ff;
   logic              clr_active_ff, clr_active_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              we;
   logic [ADDR_W-1:0] waddr;
   logic [ROW_W-1:0]  wdata;

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   // the sweep owns the write port until every row is zero
   assign we    = clr_active_ff | wr_en;
   assign waddr = clr_active_ff ? clr_addr_ff : wr_addr;
   assign wdata = clr_active_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_active_ff;

endmodule

### hw/rtl/windowed_rise_event_detector.sv
// top level: per-channel windowed rise detector with holdoff and event latches
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_stall  opcode, finger_index, pressure_0..4
//   rsp_      out         rsp_valid / rsp_stall  event_fired, pending_mask
//   csr_      in          csr_wr_en              csr_index, csr_wdata
//
// One item per cycle while req_stall is low; each result goes through the item
// stage and then the result register. The window memory is written and read at
// the transfer edge; latches and holdoff counters update as the item stage moves on.
// After reset a clearing sweep zeroes the window memory while req_stall is high.
// rsp_stall holds the result register; req_stall rises while the item stage
// cannot move on.
module windowed_rise_event_detector import wred_pkg::*; #(
   parameter int CHANNELS   = CHANNELS_DEF,
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [FINGER_W-1:0]           req_finger_index,
   input  logic signed [SAMPLE_W-1:0]    req_pressure_0,
   input  logic signed [SAMPLE_W-1:0]    req_pressure_1,
   input  logic signed [SAMPLE_W-1:0]    req_pressure_2,
   input  logic signed [SAMPLE_W-1:0]    req_pressure_3,
   input  logic signed [SAMPLE_W-1:0]    req_pressure_4,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_event_fired,
   output logic [PORT_CHANS-1:0]         rsp_pending_mask,
   input  logic                          csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   localparam int PTR_W = $clog2(WINDOW_MAX);
   localparam int LEN_W = $clog2(WINDOW_MAX + 1);
   localparam int CMP_W = (LEN_W > WLEN_W) ? LEN_W : WLEN_W;
   localparam int ROW_W = CHANNELS * SAMPLE_W;

   // configuration
   logic [WLEN_W-1:0]          wlen_ff;
   logic signed [THRESH_W-1:0] thresh_ff;
   logic [GAP_W-1:0]           gap_ff;
   logic                       en_ff;

   // window position and item stage
   logic [PTR_W-1:0] pos_ff, pos_in;
   logic             s1_valid_ff, s1_valid_in;
   opcode_type       s1_op_ff;
   logic [FINGER_W-1:0] s1_finger_ff;
   sample_type       s1_sample_ff [CHANNELS];
   logic             s1_same_ff;

   // detector state
   logic     latch_ff [CHANNELS];
   logic     latch_in [CHANNELS];
   hold_type hold_ff  [CHANNELS];
   hold_type hold_in  [CHANNELS];

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_fired_ff, rsp_fired_in;
   logic [PORT_CHANS-1:0] rsp_mask_ff, rsp_mask_in;

   logic             accept, is_sample, s1_fire, mem_busy;
   logic [CMP_W-1:0] len_eff, next_ext;
   logic [PTR_W-1:0] pos_eff, next_ptr;
   sample_type       sample_in [CHANNELS];
   logic [ROW_W-1:0] wr_row, rd_row;

   // ---------------- configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff   <= WLEN_RESET;
         thresh_ff <= THRESH_RESET;
         gap_ff    <= GAP_RESET;
         en_ff     <= EN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_WINDOW_LENGTH:  wlen_ff   <= csr_wdata[WLEN_W-1:0];
            CSR_RISE_THRESHOLD: thresh_ff <= csr_wdata[THRESH_W-1:0];
            CSR_MIN_GAP:        gap_ff    <= csr_wdata[GAP_W-1:0];
            CSR_EVENT_ENABLE:   en_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // ---------------- handshake
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = reset || mem_busy || (s1_valid_ff && !s1_fire);
   assign accept    = req_valid && !req_stall;
   assign is_sample = (opcode_type'(req_opcode) == OP_SAMPLE);

   // ---------------- window addressing
   always_comb begin
      if (CMP_W'(wlen_ff) == '0) begin
         len_eff = CMP_W'(1);
      end else if (CMP_W'(wlen_ff) > CMP_W'(WINDOW_MAX)) begin
         len_eff = CMP_W'(WINDOW_MAX);
      end else begin
         len_eff = CMP_W'(wlen_ff);
      end
      pos_eff  = (CMP_W'(pos_ff) >= len_eff) ? '0 : pos_ff;
      next_ext = CMP_W'(pos_eff) + CMP_W'(1);
      next_ptr = (next_ext >= len_eff) ? '0 : next_ext[PTR_W-1:0];
      pos_in   = (accept && is_sample) ? next_ptr : pos_ff;
   end

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         case (c)
            0:       sample_in[c] = req_pressure_0;
            1:       sample_in[c] = req_pressure_1;
            2:       sample_in[c] = req_pressure_2;
            3:       sample_in[c] = req_pressure_3;
            4:       sample_in[c] = req_pressure_4;
            default: sample_in[c] = '0;
         endcase
         wr_row[c*SAMPLE_W +: SAMPLE_W] = sample_in[c];
      end
   end

   wred_window #(
      .ROW_W (ROW_W),
      .DEPTH (WINDOW_MAX)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && is_sample),
      .wr_addr (pos_eff),
      .wr_data (wr_row),
      .rd_en   (accept && is_sample),
      .rd_addr (next_ptr),
      .rd_data (rd_row),
      .busy    (mem_busy)
   );

   // ---------------- item stage
   assign s1_valid_in = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff     <= opcode_type'(req_opcode);
         s1_finger_ff <= req_finger_index;
         // a one-slot window reads back the slot being written: rise is zero
         s1_same_ff   <= (next_ptr == pos_eff);
         for (int c = 0; c < CHANNELS; c++) begin
            s1_sample_ff[c] <= sample_in[c];
         end
      end
   end

   // ---------------- detector update
   always_comb begin
      sample_type old_val;
      rise_type   rise;
      logic       gap_ok;
      old_val      = '0;
      rise         = '0;
      gap_ok       = 1'b0;
      rsp_fired_in = 1'b0;
      rsp_mask_in  = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         latch_in[c] = latch_ff[c];
         hold_in[c]  = hold_ff[c];
         if (s1_op_ff == OP_SAMPLE) begin
            old_val = s1_same_ff ? s1_sample_ff[c] : sample_type'(rd_row[c*SAMPLE_W +: SAMPLE_W]);
            rise    = RISE_W'(s1_sample_ff[c]) - RISE_W'(old_val);
            gap_ok  = (hold_ff[c] == HOLD_NEVER) ||
                      (hold_ff[c] > $signed({{(HOLD_W-GAP_W){1'b0}}, gap_ff}));
            if (!latch_ff[c] && gap_ok && (rise > RISE_W'(thresh_ff))) begin
               latch_in[c] = 1'b1;
            end
            if (hold_ff[c] < HOLD_MAX) begin
               hold_in[c] = hold_ff[c] + hold_type'(1);
            end
         end else if ((32'(s1_finger_ff) == c) && latch_ff[c]) begin
            latch_in[c]  = 1'b0;
            hold_in[c]   = '0;
            rsp_fired_in = en_ff;
         end
         if (c < PORT_CHANS) begin
            rsp_mask_in[c] = latch_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            latch_ff[c] <= 1'b0;
            hold_ff[c]  <= HOLD_NEVER;
         end
      end else if (s1_fire) begin
         for (int c = 0; c < CHANNELS; c++) begin
            latch_ff[c] <= latch_in[c];
            hold_ff[c]  <= hold_in[c];
         end
      end
   end

   // ---------------- result register
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_fired_ff <= rsp_fired_in;
         rsp_mask_ff  <= rsp_mask_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_fired  = rsp_fired_ff;
   assign rsp_pending_mask = rsp_mask_ff;

endmodule

### hw/rtl/wred_checker.sv
// port-level checks for the windowed rise event detector, bound to the top level
module wred_checker import wred_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_event_fired,
   input logic [PORT_CHANS-1:0] rsp_pending_mask
);

   // the clearing sweep blocks input right after reset
   assert property (@(posedge clock) reset |=> req_stall)
      else $error("input accepted right after reset");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // a held result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_fired) &&
                                 $stable(rsp_pending_mask))
      else $error("stalled result changed");

endmodule

bind windowed_rise_event_detector wred_checker u_wred_checker (.*);

### sim/windowed_rise_event_detector_tb.sv
// self-checking testbench for the windowed rise event detector
`timescale 1ns / 1ps
module windowed_rise_event_detector_tb;
   import wred_pkg::*;

   typedef struct packed {
      opcode_type                  op;
      logic [FINGER_W-1:0]         finger;
      sample_type [PORT_CHANS-1:0] press;
   } detector_item_type;

   typedef struct packed {
      logic                  fired;
      logic [PORT_CHANS-1:0] pending;
   } detect_result_type;

   localparam int HOLD_SAT = 131071;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_opcode = OP_SAMPLE;
   logic [FINGER_W-1:0]       req_finger_index = '0;
   logic signed [SAMPLE_W-1:0] req_pressure_0 = '0;
   logic signed [SAMPLE_W-1:0] req_pressure_1 = '0;
   logic signed [SAMPLE_W-1:0] req_pressure_2 = '0;
   logic signed [SAMPLE_W-1:0] req_pressure_3 = '0;
   logic signed [SAMPLE_W-1:0] req_pressure_4 = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_event_fired;
   logic [PORT_CHANS-1:0]     rsp_pending_mask;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]    csr_index = CSR_WINDOW_LENGTH;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   // detector state as the testbench sees it
   sample_type            window_model [PORT_CHANS][WINDOW_MAX_DEF];
   int unsigned           slot_model;
   logic [PORT_CHANS-1:0] latch_model;
   int                    holdoff_model [PORT_CHANS];
   int unsigned           len_cfg;
   int                    thresh_cfg;
   int unsigned           gap_cfg;
   logic                  enable_cfg;

   detect_result_type predicted_events [$];
   int             error_count = 0;
   bit             req_idle_on = 1'b1;
   bit             rsp_idle_on = 1'b1;

   windowed_rise_event_detector dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_finger_index (req_finger_index),
      .req_pressure_0   (req_pressure_0),
      .req_pressure_1   (req_pressure_1),
      .req_pressure_2   (req_pressure_2),
      .req_pressure_3   (req_pressure_3),
      .req_pressure_4   (req_pressure_4),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_fired  (rsp_event_fired),
      .rsp_pending_mask (rsp_pending_mask),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic detect_result_type predict_detector(detector_item_type it);
      detect_result_type res;
      int unsigned    len, pos, nxt;
      int             rise;
      bit             gap_ok;
      res.fired = 1'b0;
      if (it.op == OP_SAMPLE) begin
         len = len_cfg;
         if (len == 0) len = 1;
         if (len > WINDOW_MAX_DEF) len = WINDOW_MAX_DEF;
         pos = (slot_model >= len) ? 0 : slot_model;
         nxt = (pos + 1 >= len) ? 0 : pos + 1;
         for (int c = 0; c < PORT_CHANS; c++) begin
            window_model[c][pos] = it.press[c];
            // oldest entry sits in the next slot; equals pos for a one-slot window
            rise = int'($signed(it.press[c])) - int'(window_model[c][nxt]);
            gap_ok = (holdoff_model[c] == -1) || (holdoff_model[c] > int'(gap_cfg));
            if (!latch_model[c] && gap_ok && rise > thresh_cfg) latch_model[c] = 1'b1;
            if (holdoff_model[c] < HOLD_SAT) holdoff_model[c]++;
         end
         slot_model = nxt;
      end else if (it.finger < PORT_CHANS && latch_model[it.finger]) begin
         latch_model[it.finger] = 1'b0;
         holdoff_model[it.finger] = 0;
         res.fired = enable_cfg;
      end
      res.pending = latch_model;
      return res;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_WINDOW_LENGTH:  len_cfg = value[WLEN_W-1:0];
         CSR_RISE_THRESHOLD: thresh_cfg = int'($signed(value));
         CSR_MIN_GAP:        gap_cfg = value[GAP_W-1:0];
         CSR_EVENT_ENABLE:   enable_cfg = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_item(input detector_item_type it);
      int gap;
      gap = req_idle_on ? idle_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= it.op;
      req_finger_index <= it.finger;
      req_pressure_0   <= it.press[0];
      req_pressure_1   <= it.press[1];
      req_pressure_2   <= it.press[2];
      req_pressure_3   <= it.press[3];
      req_pressure_4   <= it.press[4];
      do @(posedge clock); while (req_stall);
      predicted_events.push_back(predict_detector(it));
      @(negedge clock);
   endtask

   task automatic tick(input int p0, input int p1, input int p2, input int p3, input int p4);
      detector_item_type it;
      it.op       = OP_SAMPLE;
      it.finger   = $urandom_range(0, 7);
      it.press[0] = p0[SAMPLE_W-1:0];
      it.press[1] = p1[SAMPLE_W-1:0];
      it.press[2] = p2[SAMPLE_W-1:0];
      it.press[3] = p3[SAMPLE_W-1:0];
      it.press[4] = p4[SAMPLE_W-1:0];
      send_item(it);
   endtask

   task automatic consume(input int ch);
      detector_item_type it;
      it.op     = OP_CONSUME;
      it.finger = ch[FINGER_W-1:0];
      for (int c = 0; c < PORT_CHANS; c++) it.press[c] = $urandom_range(0, 65535);
      send_item(it);
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (predicted_events.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic test_latch_and_consume();
      tick(32767, -32768, 1000, 1001, 0);
      consume(0);
      consume(0);
      consume(3);
      consume(5);
      consume(7);
      // channel 0 was just consumed, so the holdoff blocks it for one tick
      tick(32767, 0, 0, 0, 0);
      tick(32767, 0, 0, 0, 0);
   endtask

   task automatic test_event_disabled();
      wait_quiet();
      write_reg(CSR_EVENT_ENABLE, 0);
      consume(0);
      tick(5000, 5000, 5000, 5000, 5000);
      consume(1);
      wait_quiet();
      write_reg(CSR_EVENT_ENABLE, 1);
   endtask

   task automatic test_window_and_threshold();
      wait_quiet();
      write_reg(CSR_RISE_THRESHOLD, 0);
      write_reg(CSR_WINDOW_LENGTH, 0);
      tick(32767, 32767, 32767, 32767, 32767);
      tick(-32768, -32768, -32768, -32768, -32768);
      wait_quiet();
      write_reg(CSR_WINDOW_LENGTH, 127);
      tick(2000, -2000, 0, 1, -1);
      wait_quiet();
      write_reg(CSR_WINDOW_LENGTH, 2);
      write_reg(CSR_RISE_THRESHOLD, 65535);
      for (int c = 0; c < PORT_CHANS; c++) consume(c);
      // full-scale rise equals the threshold, which is not enough
      tick(-32768, -32768, -32768, -32768, -32768);
      tick(32767, 32767, 32767, 32767, 32767);
      wait_quiet();
      write_reg(CSR_RISE_THRESHOLD, -65536);
      tick(-32768, -32768, -32768, -32768, -32768);
   endtask

   task automatic test_holdoff_gap();
      wait_quiet();
      write_reg(CSR_WINDOW_LENGTH, 1);
      write_reg(CSR_RISE_THRESHOLD, -1);
      write_reg(CSR_MIN_GAP, 0);
      tick(0, 0, 0, 0, 0);
      tick(0, 0, 0, 0, 0);
      for (int c = 0; c < PORT_CHANS; c++) consume(c);
      wait_quiet();
      write_reg(CSR_RISE_THRESHOLD, 65535);
      write_reg(CSR_MIN_GAP, 65535);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      // counters stay far below the gap, so the last tick must not latch
      repeat (20) tick($urandom, $urandom, $urandom, $urandom, $urandom);
      wait_quiet();
      write_reg(CSR_RISE_THRESHOLD, -1);
      tick(0, 0, 0, 0, 0);
      wait_quiet();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      detector_item_type     it;
      int                    walk_level [PORT_CHANS];
      int                    lvl;
      logic [CSR_DATA_W-1:0] th;
      for (int phase = 0; phase < 9; phase++) begin
         wait_quiet();
         case ($urandom_range(0, 7))
            0: write_reg(CSR_WINDOW_LENGTH, 0);
            1: write_reg(CSR_WINDOW_LENGTH, 1);
            2: write_reg(CSR_WINDOW_LENGTH, 64);
            3: write_reg(CSR_WINDOW_LENGTH, $urandom_range(65, 127));
            4: write_reg(CSR_WINDOW_LENGTH, 2);
            default: write_reg(CSR_WINDOW_LENGTH, $urandom_range(3, 20));
         endcase
         case ($urandom_range(0, 9))
            0: th = 17'h10000;
            1: th = 17'h0FFFF;
            2: th = '0;
            3: th = $urandom_range(0, 131071);
            4: th = 0 - $urandom_range(0, 500);
            default: th = $urandom_range(200, 4000);
         endcase
         write_reg(CSR_RISE_THRESHOLD, th);
         case ($urandom_range(0, 7))
            0: write_reg(CSR_MIN_GAP, 65535);
            1: write_reg(CSR_MIN_GAP, $urandom_range(0, 65535));
            default: write_reg(CSR_MIN_GAP, $urandom_range(0, 6));
         endcase
         write_reg(CSR_EVENT_ENABLE, $urandom_range(0, 3) != 0);
         req_idle_on = $urandom_range(0, 3) != 0;
         rsp_idle_on = $urandom_range(0, 3) != 0;
         for (int n = 0; n < 145; n++) begin
            it.finger = $urandom_range(0, 7);
            for (int c = 0; c < PORT_CHANS; c++) it.press[c] = $urandom_range(0, 65535);
            if ($urandom_range(0, 9) < 3) begin
               it.op = OP_CONSUME;
               // mostly consume a channel that actually holds an event
               if (latch_model != '0 && $urandom_range(0, 3) != 0) begin
                  do it.finger = $urandom_range(0, PORT_CHANS - 1);
                  while (!latch_model[it.finger]);
               end
            end else begin
               it.op = OP_SAMPLE;
               for (int c = 0; c < PORT_CHANS; c++) begin
                  case ($urandom_range(0, 9))
                     0: lvl = $signed(it.press[c]);
                     1: lvl = 32767;
                     2: lvl = -32768;
                     default: lvl = walk_level[c] + $urandom_range(0, 2400) - 1200;
                  endcase
                  if (lvl > 32767) lvl = 32767;
                  if (lvl < -32768) lvl = -32768;
                  walk_level[c] = lvl;
                  it.press[c] = lvl[SAMPLE_W-1:0];
               end
            end
            send_item(it);
         end
      end
   endtask

   initial begin : stimulus
      len_cfg     = WLEN_RESET;
      thresh_cfg  = int'($signed(THRESH_RESET));
      gap_cfg     = GAP_RESET;
      enable_cfg  = EN_RESET;
      slot_model  = 0;
      latch_model = '0;
      for (int c = 0; c < PORT_CHANS; c++) begin
         holdoff_model[c] = -1;
         for (int s = 0; s < WINDOW_MAX_DEF; s++) window_model[c][s] = '0;
      end
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_latch_and_consume();
      test_event_disabled();
      test_window_and_threshold();
      test_holdoff_gap();
      test_random_traffic();
      wait_quiet();
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : rsp_backpressure
      int hold;
      @(negedge clock);
      forever begin
         hold = rsp_idle_on ? idle_len() : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   always @(posedge clock) begin : result_check
      detect_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_events.size() == 0) begin
            $error("unexpected transfer: event_fired %0b pending_mask %05b",
                   rsp_event_fired, rsp_pending_mask);
            error_count++;
         end else begin
            want = predicted_events.pop_front();
            if (rsp_event_fired !== want.fired) begin
               $error("event_fired expected %0b actual %0b", want.fired, rsp_event_fired);
               error_count++;
            end
            if (rsp_pending_mask !== want.pending) begin
               $error("pending_mask expected %05b actual %05b", want.pending,
                      rsp_pending_mask);
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
